/* hw/rtl/lsrd_pkg.sv */
// Shared types and constants for the log storage record deframer.
package lsrd_pkg;

    localparam logic [23:0] SYNC_HEAD       = 24'h444C54;  // 'D','L','T'
    localparam logic [7:0]  SYNC_LAST       = 8'h01;
    localparam logic [16:0] STORAGE_HDR_LEN = 17'd16;
    localparam logic [16:0] SHORT_REC_LIMIT = 17'd20;      // storage + standard header
    localparam logic [16:0] FIRST_HDR_POS   = 17'd4;       // first byte after the sync
    localparam logic [16:0] LEN_HI_POS      = 17'd18;
    localparam logic [16:0] LEN_LO_POS      = 17'd19;
    localparam logic [31:0] SYNC_BACKSTEP   = 32'd3;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_HEAD = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        logic [31:0] record_index;
        logic [31:0] record_offset;
        logic [16:0] record_length;
    } result_t;

endpackage

/* hw/rtl/lsrd_in_stage.sv */
// Input register stage: holds one item until the deframer core takes it.
module lsrd_in_stage
    import lsrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    input  logic       take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{data_byte: data_byte, end_of_stream: end_of_stream};
        end
    end

endmodule

/* hw/rtl/lsrd_core.sv */
// Deframer core: sync hunt, header length capture and record end detection.
module lsrd_core
    import lsrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    fire,
    output logic    emit,
    output result_t result
);

    phase_t      phase_reg,      phase_next;
    logic [23:0] recent_reg,     recent_next;
    logic [16:0] count_reg,      count_next;
    logic [7:0]  len_high_reg,   len_high_next;
    logic [16:0] cap_len_reg,    cap_len_next;
    logic [31:0] position_reg,   position_next;
    logic [31:0] start_reg,      start_next;
    logic [31:0] counter_reg,    counter_next;

    logic [16:0] count_inc;
    logic [16:0] head_len;

    assign count_inc = count_reg + 17'd1;
    assign head_len  = {1'b0, len_high_reg, item.data_byte} + STORAGE_HDR_LEN;

    always_comb
    begin
        phase_next    = phase_reg;
        recent_next   = recent_reg;
        count_next    = count_reg;
        len_high_next = len_high_reg;
        cap_len_next  = cap_len_reg;
        start_next    = start_reg;
        counter_next  = counter_reg;
        emit          = 1'b0;
        result        = '{record_index: counter_reg, record_offset: start_reg,
                          record_length: cap_len_reg};

        case (phase_reg)
            PH_HEAD:
            begin
                if (count_reg == LEN_HI_POS)
                begin
                    len_high_next = item.data_byte;
                end
                count_next = count_inc;
                if (count_reg == LEN_LO_POS)
                begin
                    cap_len_next         = head_len;
                    result.record_length = head_len;
                    if (head_len <= SHORT_REC_LIMIT)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                count_next = count_inc;
                if (count_inc >= cap_len_reg)
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (item.data_byte == SYNC_LAST && recent_reg == SYNC_HEAD)
                begin
                    start_next    = position_reg - SYNC_BACKSTEP;
                    count_next    = FIRST_HDR_POS;
                    len_high_next = 8'd0;
                    cap_len_next  = 17'd0;
                    recent_next   = 24'd0;
                    phase_next    = PH_HEAD;
                end
                else
                begin
                    recent_next = {recent_reg[15:0], item.data_byte};
                end
            end
        endcase

        if (emit)
        begin
            counter_next = counter_reg + 32'd1;
            phase_next   = PH_HUNT;
            recent_next  = 24'd0;
            count_next   = 17'd0;
        end

        position_next = position_reg + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            recent_reg   <= 24'd0;
            count_reg    <= 17'd0;
            len_high_reg <= 8'd0;
            cap_len_reg  <= 17'd0;
            position_reg <= 32'd0;
            start_reg    <= 32'd0;
            counter_reg  <= 32'd0;
        end
        else if (fire)
        begin
            if (item.end_of_stream)
            begin
                // end of stream: everything back to the reset state
                phase_reg    <= PH_HUNT;
                recent_reg   <= 24'd0;
                count_reg    <= 17'd0;
                len_high_reg <= 8'd0;
                cap_len_reg  <= 17'd0;
                position_reg <= 32'd0;
                start_reg    <= 32'd0;
                counter_reg  <= 32'd0;
            end
            else
            begin
                phase_reg    <= phase_next;
                recent_reg   <= recent_next;
                count_reg    <= count_next;
                len_high_reg <= len_high_next;
                cap_len_reg  <= cap_len_next;
                position_reg <= position_next;
                start_reg    <= start_next;
                counter_reg  <= counter_next;
            end
        end
    end

endmodule

/* hw/rtl/lsrd_out_stage.sv */
// Result register stage: holds one record descriptor until it is taken.
module lsrd_out_stage
    import lsrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     result,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] record_index,
    output logic [31:0] record_offset,
    output logic [16:0] record_length
);

    logic    valid_reg;
    result_t result_reg;

    assign out_valid     = valid_reg;
    assign record_index  = result_reg.record_index;
    assign record_offset = result_reg.record_offset;
    assign record_length = result_reg.record_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

/* hw/rtl/log_storage_record_deframer.sv */
// Log storage record deframer: one byte per item in, one record descriptor per record out.
// Throughput: one byte item per clock, sustained, while results are taken.
// A record's last byte is held in the input register, then its descriptor in the result register.
// The input register and the result register part the two sides; a byte that completes
//   a record waits only while the result register is full and not being drained.
// Reset (rst_n low, asynchronous) empties both stages and puts the hunt, offset and index at zero.
module log_storage_record_deframer
    import lsrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] record_index,
    output logic [31:0] record_offset,
    output logic [16:0] record_length
);

    logic    item_valid;
    item_t   item;
    logic    emit;
    logic    fire;
    result_t result;

    // a byte with no result never waits on the output side
    assign fire = item_valid && (!emit || !out_valid || out_ready);

    lsrd_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .take          (fire),
        .item_valid    (item_valid),
        .item          (item)
    );

    lsrd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .fire   (fire),
        .emit   (emit),
        .result (result)
    );

    lsrd_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire && emit),
        .result        (result),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_index  (record_index),
        .record_offset (record_offset),
        .record_length (record_length)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit && out_valid) |-> out_ready)
        else $error("result register overwritten before it was taken");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit) |=> out_valid)
        else $error("emitted record did not reach the result register");

    a_length_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (record_length >= STORAGE_HDR_LEN))
        else $error("record length below storage header size");

endmodule

/* sim/log_storage_record_deframer_tb.sv */
// Testbench for the log storage record deframer: byte stream in, record descriptors checked out.
`timescale 1ns / 100ps

module log_storage_record_deframer_tb
    import lsrd_pkg::*;
();

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_BYTES = 1200;
    localparam int CALM_TAIL    = 150;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        item_t payload;
        bit    wait_drain;
        bit    long_hold;
    } stim_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte     = 8'h00;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [31:0] record_index;
    logic [31:0] record_offset;
    logic [16:0] record_length;

    // driver -> monitor controls, one nonblocking write per edge each
    logic hold_request = 1'b0;
    logic calm_phase   = 1'b0;

    stim_t   stim_q[$];
    result_t expected_records[$];
    result_t due_record;

    int error_count     = 0;
    int predicted_count = 0;
    int checked_count   = 0;
    int cycle_count     = 0;
    int gap_left        = 0;
    int stall_left      = 0;
    int hold_left       = 0;

    // deframer state as predicted from the accepted bytes
    logic [23:0] hunt_window;
    phase_t      deframe_phase;
    logic [16:0] record_byte_count;
    logic [7:0]  len_hi_byte;
    logic [16:0] full_length;
    logic [31:0] byte_offset;
    logic [31:0] sync_offset;
    logic [31:0] records_emitted;

    log_storage_record_deframer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_index  (record_index),
        .record_offset (record_offset),
        .record_length (record_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic clear_deframe_state();
        hunt_window       = '0;
        deframe_phase     = PH_HUNT;
        record_byte_count = '0;
        len_hi_byte       = '0;
        full_length       = '0;
        byte_offset       = '0;
        sync_offset       = '0;
        records_emitted   = '0;
    endtask

    task automatic frame_byte(input item_t it);
        logic [16:0] idx;
        result_t     rec;
        bit          done;
        done = 1'b0;
        idx  = record_byte_count;
        case (deframe_phase)
            PH_HEAD:
            begin
                if (idx == LEN_HI_POS)
                    len_hi_byte = it.data_byte;
                record_byte_count = record_byte_count + 17'd1;
                if (idx == LEN_LO_POS)
                begin
                    full_length = {1'b0, len_hi_byte, it.data_byte} + STORAGE_HDR_LEN;
                    // a record no longer than the two headers ends on the length byte
                    if (full_length <= SHORT_REC_LIMIT)
                        done = 1'b1;
                    else
                        deframe_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                record_byte_count = record_byte_count + 17'd1;
                if (record_byte_count >= full_length)
                    done = 1'b1;
            end
            default:
            begin
                deframe_phase = PH_HUNT;
                if (it.data_byte == SYNC_LAST && hunt_window == SYNC_HEAD)
                begin
                    sync_offset       = byte_offset - SYNC_BACKSTEP;
                    record_byte_count = FIRST_HDR_POS;
                    len_hi_byte       = '0;
                    full_length       = '0;
                    hunt_window       = '0;
                    deframe_phase     = PH_HEAD;
                end
                else
                    hunt_window = {hunt_window[15:0], it.data_byte};
            end
        endcase
        if (done)
        begin
            rec.record_index  = records_emitted;
            rec.record_offset = sync_offset;
            rec.record_length = full_length;
            expected_records  = {expected_records, rec};
            predicted_count++;
            records_emitted   = records_emitted + 32'd1;
            deframe_phase     = PH_HUNT;
            hunt_window       = '0;
            record_byte_count = '0;
        end
        byte_offset = byte_offset + 32'd1;
        if (it.end_of_stream)
            clear_deframe_state();
    endtask

    task automatic add_byte(input logic [7:0] b, input bit eos, input bit drain, input bit hold);
        stim_t s;
        s.payload.data_byte     = b;
        s.payload.end_of_stream = eos;
        s.wait_drain            = drain;
        s.long_hold             = hold;
        stim_q = {stim_q, s};
    endtask

    // cut > 0 sends only that many bytes, the last one flagged as end of stream
    task automatic add_record(input logic [15:0] len_field, input int cut, input bit eos_last,
                              input bit embed_sync, input bit drain, input bit hold);
        int total;
        int sent;
        logic [7:0] b;
        total = int'(len_field) + 16;
        if (total < 20)
            total = 20;
        sent = (cut > 0) ? cut : total;
        for (int k = 0; k < sent; k++)
        begin
            case (k)
                0:       b = SYNC_HEAD[23:16];
                1:       b = SYNC_HEAD[15:8];
                2:       b = SYNC_HEAD[7:0];
                3:       b = SYNC_LAST;
                18:      b = len_field[15:8];
                19:      b = len_field[7:0];
                default: b = 8'($urandom);
            endcase
            if (embed_sync && total >= 24 && k >= 20 && k < 24)
                b = (k == 23) ? SYNC_LAST : SYNC_HEAD[8*(22-k) +: 8];
            add_byte(b, (k == sent - 1) && (cut > 0 || eos_last), (k == 0) && drain,
                     (k == 0) && hold);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        stim_t nxt;
        logic  hold_next;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            data_byte     <= 8'h00;
            end_of_stream <= 1'b0;
            hold_request  <= 1'b0;
            calm_phase    <= 1'b0;
        end
        else
        begin
            hold_next = 1'b0;
            if (in_valid && in_ready)
                frame_byte('{data_byte: data_byte, end_of_stream: end_of_stream});
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stim_q.size() == 0)
                    in_valid <= 1'b0;
                else if (stim_q[0].wait_drain && checked_count != predicted_count)
                    in_valid <= 1'b0;
                else if (!calm_phase && $urandom_range(0, 9) == 0)
                begin
                    gap_left = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = stim_q.pop_front();
                    data_byte     <= nxt.payload.data_byte;
                    end_of_stream <= nxt.payload.end_of_stream;
                    in_valid      <= 1'b1;
                    hold_next     = nxt.long_hold;
                end
            end
            hold_request <= hold_next;
            calm_phase   <= (stim_q.size() < CALM_TAIL);
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_records.size() == 0)
                begin
                    $display("%0t: record with nothing expected: index %0d offset %0d length %0d",
                             $time, record_index, record_offset, record_length);
                    error_count++;
                end
                else
                begin
                    due_record = expected_records.pop_front();
                    if (record_index !== due_record.record_index)
                    begin
                        $display("%0t: record_index expected %0d actual %0d",
                                 $time, due_record.record_index, record_index);
                        error_count++;
                    end
                    if (record_offset !== due_record.record_offset)
                    begin
                        $display("%0t: record_offset expected %0d actual %0d",
                                 $time, due_record.record_offset, record_offset);
                        error_count++;
                    end
                    if (record_length !== due_record.record_length)
                    begin
                        $display("%0t: record_length expected %0d actual %0d",
                                 $time, due_record.record_length, record_length);
                        error_count++;
                    end
                    checked_count <= checked_count + 1;
                end
            end
            if (hold_request)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm_phase && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int record_bytes;
        int pick;
        int len;
        int total;
        int cut;
        int before_add;
        bit first_random;

        clear_deframe_state();

        // near-misses of the sync word, then back-to-back records
        add_byte(8'h00, 1'b0, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        add_byte(SYNC_HEAD[23:16], 1'b0, 1'b0, 1'b0);
        add_byte(SYNC_HEAD[15:8], 1'b0, 1'b0, 1'b0);
        add_byte(SYNC_HEAD[7:0], 1'b0, 1'b0, 1'b0);
        add_byte(8'h02, 1'b0, 1'b0, 1'b0);
        add_byte(SYNC_HEAD[23:16], 1'b0, 1'b0, 1'b0);
        add_record(16'd0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_record(16'd4, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_record(16'd5, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_record(16'd14, 0, 1'b0, 1'b1, 1'b0, 1'b0);
        // end of stream on the length byte of a short record
        add_record(16'd3, 0, 1'b1, 1'b0, 1'b0, 1'b0);
        add_record(16'd40, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        // truncated in the header, then end of stream on the sync byte itself
        add_record(16'd40, 10, 1'b0, 1'b0, 1'b0, 1'b0);
        add_record(16'd40, 4, 1'b0, 1'b0, 1'b0, 1'b0);
        add_byte(8'h55, 1'b1, 1'b0, 1'b0);
        add_record(16'd200, 150, 1'b0, 1'b0, 1'b0, 1'b0);
        // largest length field, cut short by end of stream
        add_record(16'hFFFF, 40, 1'b0, 1'b0, 1'b0, 1'b0);

        record_bytes = 0;
        first_random = 1'b1;
        while (record_bytes < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    if (k < 3 && pick < 6)
                        add_byte(SYNC_HEAD[8*(2-k) +: 8], 1'b0, 1'b0, 1'b0);
                    else
                        add_byte(8'($urandom), (k == len - 1) && $urandom_range(0, 19) == 0,
                                 1'b0, 1'b0);
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                len  = (pick < 90) ? $urandom_range(0, 48) : $urandom_range(49, 400);
                total = (len + 16 < 20) ? 20 : len + 16;
                pick = $urandom_range(0, 99);
                cut  = (pick < 6) ? $urandom_range(1, total - 1) : 0;
                before_add = stim_q.size();
                add_record(16'(len), cut, pick >= 6 && pick < 14, $urandom_range(0, 9) == 0,
                           first_random || $urandom_range(0, 49) == 0, first_random);
                record_bytes += stim_q.size() - before_add;
                first_random = 1'b0;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_valid)
            @(posedge clk);
        while (checked_count != predicted_count)
            @(posedge clk);
        repeat (16) @(posedge clk);

        while (expected_records.size() != 0)
        begin
            due_record = expected_records.pop_front();
            $display("%0t: record never came: index %0d offset %0d length %0d", $time,
                     due_record.record_index, due_record.record_offset,
                     due_record.record_length);
            error_count++;
        end

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
